FILE: rtl/uncd_pkg.sv
// Package for the packed Unicode name decoder.
// Holds the input mode codes, the flag codes, the sequencer states and the result flags.
// No dependencies.
package uncd_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_CHAR    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_NONE    = 2'd3
  } uncd_mode_t;

  typedef enum logic [1:0] {
    CODE_LIT  = 2'd0,
    CODE_BASE = 2'd1,
    CODE_PAIR = 2'd2,
    CODE_RUN  = 2'd3
  } uncd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GOT_FLAG,
    ST_GOT1,
    ST_GOT_HI,
    ST_GOT_CORR,
    ST_EMIT
  } uncd_state_t;

  typedef struct packed {
    logic is_end;
    logic past_end;
  } uncd_flags_t;

  localparam logic [10:0] MAX_CHARS_RESET = 11'd1024;
  localparam logic [3:0]  FLAG_BITS       = 4'd8;

endpackage

FILE: rtl/uncd_store.sv
// Single-port byte store for the encoded name, one access per cycle.
// Read data is registered; depends on nothing.
module uncd_store #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [7:0]               wdata,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/uncd_ctrl.sv
// Decode sequencer: loads the store, fetches flag, length, correction and data bytes.
// Depends on uncd_pkg; drives the port of uncd_store.
module uncd_ctrl
  import uncd_pkg::*;
#(
  parameter int ENC_DEPTH = 2048,
  parameter int MAX_NAME  = 1024,
  localparam int AW  = $clog2(ENC_DEPTH),
  localparam int RPW = $clog2(ENC_DEPTH + 1),
  localparam int IW  = $clog2(MAX_NAME),
  localparam int PW  = $clog2(MAX_NAME + 1),
  localparam int LW  = (PW > 11) ? PW : 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  uncd_mode_t        in_mode,
  input  logic [7:0]        in_byte,
  input  logic [10:0]       max_chars,
  output logic              mem_we,
  output logic [AW-1:0]     mem_addr,
  output logic [7:0]        mem_wdata,
  input  logic [7:0]        mem_rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [15:0]       res_char,
  output logic [IW-1:0]     res_index,
  output uncd_flags_t       res_flags
);

  uncd_state_t state, state_next;

  logic [RPW-1:0] count;
  logic [RPW-1:0] rp;
  logic [7:0]     base;
  logic [7:0]     flags;
  logic [3:0]     bits;
  logic [7:0]     run_left;
  logic           run_corr;
  logic [7:0]     corr;
  logic [PW-1:0]  pos;
  logic           fin;
  logic [7:0]     nat;
  logic [7:0]     lo;
  logic [7:0]     len;
  logic           rd_ok;

  logic           accept;
  logic           issue;
  logic [7:0]     fdata;
  uncd_code_t     code;
  logic [LW-1:0]  mc_ext;
  logic [LW-1:0]  lim;
  logic           at_limit;
  logic           go_decode;
  logic [15:0]    run_val;

  assign accept    = in_valid && in_ready;
  assign fdata     = rd_ok ? mem_rdata : 8'h00;
  assign code      = uncd_code_t'(flags[7:6]);
  assign mc_ext    = LW'(max_chars);
  assign lim       = (mc_ext == '0) ? LW'(1) :
                     (mc_ext > LW'(MAX_NAME)) ? LW'(MAX_NAME) : mc_ext;
  assign at_limit  = LW'(pos) >= (lim - LW'(1));
  assign go_decode = !fin && !at_limit && (run_left == 8'd0) && (rp < count);
  assign run_val   = run_corr ? {base, in_byte + corr} : {8'h00, in_byte};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_mode == MODE_CHAR) begin
          if (go_decode) begin
            state_next = (bits == 4'd0) ? ST_GOT_FLAG : ST_GOT1;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_GOT_FLAG: state_next = ST_GOT1;
      ST_GOT1: begin
        case (code)
          CODE_PAIR: state_next = ST_GOT_HI;
          CODE_RUN:  state_next = fdata[7] ? ST_GOT_CORR : ST_EMIT;
          default:   state_next = ST_EMIT;
        endcase
      end
      ST_GOT_HI:   state_next = ST_EMIT;
      ST_GOT_CORR: state_next = ST_EMIT;
      ST_EMIT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    res_valid = (state == ST_EMIT);
    mem_we    = 1'b0;
    issue     = 1'b0;
    case (state)
      ST_IDLE: begin
        mem_we = accept && in_mode == MODE_LOAD && count < RPW'(ENC_DEPTH);
        issue  = accept && in_mode == MODE_CHAR && go_decode;
      end
      ST_GOT_FLAG: issue = 1'b1;
      ST_GOT1:     issue = (code == CODE_PAIR) || (code == CODE_RUN && fdata[7]);
      default: begin
        mem_we = 1'b0;
        issue  = 1'b0;
      end
    endcase
    mem_addr  = mem_we ? count[AW-1:0] : rp[AW-1:0];
    mem_wdata = in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rp       <= RPW'(1);
      base     <= 8'h00;
      flags    <= 8'h00;
      bits     <= 4'd0;
      run_left <= 8'd0;
      run_corr <= 1'b0;
      corr     <= 8'h00;
      pos      <= '0;
      fin      <= 1'b0;
      rd_ok    <= 1'b0;
    end else begin
      state <= state_next;
      if (issue) begin
        rd_ok <= rp < count;
        if (rp != RPW'(ENC_DEPTH)) begin
          rp <= rp + RPW'(1);
        end
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (in_mode)
              MODE_LOAD: begin
                if (count < RPW'(ENC_DEPTH)) begin
                  count <= count + RPW'(1);
                  if (count == '0) begin
                    base <= in_byte;
                  end
                end
              end
              MODE_RESTART: begin
                count    <= '0;
                rp       <= RPW'(1);
                base     <= 8'h00;
                flags    <= 8'h00;
                bits     <= 4'd0;
                run_left <= 8'd0;
                run_corr <= 1'b0;
                corr     <= 8'h00;
                pos      <= '0;
                fin      <= 1'b0;
              end
              MODE_CHAR: begin
                nat       <= in_byte;
                res_index <= (pos > PW'(MAX_NAME - 1)) ? IW'(MAX_NAME - 1)
                                                       : pos[IW-1:0];
                if (pos < PW'(MAX_NAME)) begin
                  pos <= pos + PW'(1);
                end
                if (fin) begin
                  res_char  <= 16'h0000;
                  res_flags <= '{is_end: 1'b0, past_end: 1'b1};
                end else if (at_limit || (run_left == 8'd0 && !(rp < count))) begin
                  res_char  <= 16'h0000;
                  res_flags <= '{is_end: 1'b1, past_end: 1'b0};
                  fin       <= 1'b1;
                end else if (run_left != 8'd0) begin
                  res_char  <= run_val;
                  res_flags <= '0;
                  run_left  <= run_left - 8'd1;
                end else begin
                  res_char  <= 16'h0000;
                  res_flags <= '0;
                end
              end
              default: begin
                nat <= nat;
              end
            endcase
          end
        end
        ST_GOT_FLAG: begin
          flags <= fdata;
          bits  <= FLAG_BITS;
        end
        ST_GOT1: begin
          case (code)
            CODE_LIT: begin
              res_char <= {8'h00, fdata};
              flags    <= {flags[5:0], 2'b00};
              bits     <= bits - 4'd2;
            end
            CODE_BASE: begin
              res_char <= {base, fdata};
              flags    <= {flags[5:0], 2'b00};
              bits     <= bits - 4'd2;
            end
            CODE_PAIR: begin
              lo <= fdata;
            end
            default: begin
              len <= fdata;
              if (!fdata[7]) begin
                run_corr <= 1'b0;
                res_char <= {8'h00, nat};
                run_left <= fdata + 8'd1;
                flags    <= {flags[5:0], 2'b00};
                bits     <= bits - 4'd2;
              end
            end
          endcase
        end
        ST_GOT_HI: begin
          res_char <= {fdata, lo};
          flags    <= {flags[5:0], 2'b00};
          bits     <= bits - 4'd2;
        end
        ST_GOT_CORR: begin
          corr     <= fdata;
          run_corr <= 1'b1;
          res_char <= {base, nat + fdata};
          run_left <= {1'b0, len[6:0]} + 8'd1;
          flags    <= {flags[5:0], 2'b00};
          bits     <= bits - 4'd2;
        end
        default: begin
          nat <= nat;
        end
      endcase
    end
  end

endmodule

FILE: rtl/packed_unicode_name_decoder.sv
// Top level of the packed Unicode name decoder: capacity register and output register.
// Depends on uncd_pkg, uncd_store and uncd_ctrl.
//
// Mode-0 beats load the encoded name one byte a cycle, while the sequencer is idle, into a
// single-port store; the first byte is the high-byte base. Each mode-1 beat carries one native
// name byte and yields one 16-bit character beat. A character is accepted, then each encoded
// byte it needs is read from the store in turn (flag byte, then data, length, low/high pair or
// correction byte, each a read of its own on the single store port), and the result is handed
// to the output register. Characters inside a run, the terminator and beats after the end read
// no store byte. A mode-2 beat restarts the decoder and gives no result; mode 3 is ignored.
module packed_unicode_name_decoder
  import uncd_pkg::*;
#(
  parameter int ENC_DEPTH = 2048,
  parameter int MAX_NAME  = 1024,
  localparam int IW = $clog2(MAX_NAME),
  localparam int DW = ((16 + IW + 7) / 8) * 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // data_byte
  input  logic [1:0]    s_tuser,   // mode
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [DW-1:0] m_tdata,   // char_code, char_index, zero fill
  output logic          m_tlast,   // is_end
  output logic [0:0]    m_tuser,   // past_end
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [10:0]   cfg_data   // max_chars
);

  logic [10:0]              max_chars;
  logic                     mem_we;
  logic [$clog2(ENC_DEPTH)-1:0] mem_addr;
  logic [7:0]               mem_wdata;
  logic [7:0]               mem_rdata;
  logic                     res_valid;
  logic                     res_ready;
  logic [15:0]              res_char;
  logic [IW-1:0]            res_index;
  uncd_flags_t              res_flags;

  assign cfg_ready = 1'b1;
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= MAX_CHARS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_chars <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata    <= DW'({res_index, res_char});
      m_tlast    <= res_flags.is_end;
      m_tuser[0] <= res_flags.past_end;
    end
  end

  uncd_store #(
    .DEPTH (ENC_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  uncd_ctrl #(
    .ENC_DEPTH (ENC_DEPTH),
    .MAX_NAME  (MAX_NAME)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (uncd_mode_t'(s_tuser)),
    .in_byte   (s_tdata),
    .max_chars (max_chars),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_char  (res_char),
    .res_index (res_index),
    .res_flags (res_flags)
  );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for packed_unicode_name_decoder: encoded names are loaded and decoded
// under random sender bursts and receiver stalls, and each character beat is checked against
// an in-bench model of the decoder. Depends on uncd_pkg and the decoder RTL.
module testbench;
  import uncd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENC_DEPTH = 2048;
  localparam int MAX_NAME  = 1024;
  localparam int DW        = ((16 + $clog2(MAX_NAME) + 7) / 8) * 8;

  localparam logic [7:0] SAMPLE_NAME [8] = '{8'hFF, 8'h1B, 8'h00, 8'hFF, 8'h34, 8'h12, 8'h80,
                                             8'hFF};
  localparam logic [7:0] SAMPLE_NATIVE [7] = '{8'hFF, 8'h00, 8'h55, 8'h01, 8'hFF, 8'h80, 8'hAA};
  localparam logic [10:0] CAP_EXTREMES [6] = '{11'd0, 11'd1, 11'd2, 11'd2047, 11'd1025, 11'd1024};

  typedef struct {
    uncd_mode_t mode;
    logic [7:0] data;
  } name_beat_t;

  typedef struct packed {
    logic [15:0] code;
    logic [9:0]  index;
    logic        is_end;
    logic        past_end;
  } char_beat_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [7:0]    s_tdata = 8'h00;
  logic [1:0]    s_tuser = 2'd0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [DW-1:0] m_tdata;
  logic          m_tlast;
  logic [0:0]    m_tuser;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [10:0]   cfg_data = 11'd0;

  name_beat_t pend_q[$];
  char_beat_t expected_chars[$];
  int         errors = 0;
  int         fed = 0;

  // Decoder model state.
  logic [7:0] enc_mem [ENC_DEPTH];
  int         enc_count;
  int         rd_ptr;
  logic [7:0] base_hi;
  logic [7:0] flags;
  int         flag_left;
  int         run_cnt;
  logic       run_fix;
  logic [7:0] fix_val;
  int         out_pos;
  logic       done;
  int         cap = MAX_CHARS_RESET;

  int burst_left = 1;
  int gap_left = 0;
  int rdy_mode = 0;
  int rdy_left = 0;
  int rdy_tick = 0;

  packed_unicode_name_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_decoder();
    enc_count = 0;
    rd_ptr = 1;
    base_hi = 8'h00;
    flags = 8'h00;
    flag_left = 0;
    run_cnt = 0;
    run_fix = 1'b0;
    fix_val = 8'h00;
    out_pos = 0;
    done = 1'b0;
  endfunction

  function automatic logic [7:0] next_enc();
    logic [7:0] v;
    v = 8'h00;
    if (rd_ptr < enc_count) v = enc_mem[rd_ptr];
    rd_ptr++;
    return v;
  endfunction

  function automatic logic [15:0] run_char(input logic [7:0] nat);
    if (run_fix) return {base_hi, 8'(nat + fix_val)};
    return {8'h00, nat};
  endfunction

  function automatic bit decode_beat(input name_beat_t b, output char_beat_t c);
    int         lim;
    int         pos;
    int         cnt;
    logic [7:0] lo;
    logic [7:0] len;
    uncd_code_t code;
    c = '0;
    if (b.mode == MODE_LOAD) begin
      if (enc_count < ENC_DEPTH) begin
        if (enc_count == 0) base_hi = b.data;
        enc_mem[enc_count] = b.data;
        enc_count++;
      end
      return 1'b0;
    end
    if (b.mode == MODE_RESTART) begin
      clear_decoder();
      return 1'b0;
    end
    if (b.mode != MODE_CHAR) return 1'b0;
    lim = (cap < 1) ? 1 : ((cap > MAX_NAME) ? MAX_NAME : cap);
    pos = out_pos;
    if (done) begin
      c.past_end = 1'b1;
    end else if (pos >= lim - 1) begin
      c.is_end = 1'b1;
      done = 1'b1;
    end else if (run_cnt > 0) begin
      c.code = run_char(b.data);
      run_cnt--;
    end else if (rd_ptr >= enc_count) begin
      c.is_end = 1'b1;
      done = 1'b1;
    end else begin
      if (flag_left == 0) begin
        flags = next_enc();
        flag_left = FLAG_BITS;
      end
      code = uncd_code_t'(flags[7:6]);
      case (code)
        CODE_LIT: c.code = {8'h00, next_enc()};
        CODE_BASE: c.code = {base_hi, next_enc()};
        CODE_PAIR: begin
          lo = next_enc();
          c.code = {next_enc(), lo};
        end
        default: begin
          len = next_enc();
          run_fix = len[7];
          if (len[7]) begin
            fix_val = next_enc();
            cnt = len[6:0] + 2;
          end else begin
            cnt = len + 2;
          end
          c.code = run_char(b.data);
          run_cnt = cnt - 1;
        end
      endcase
      flags = flags << 2;
      flag_left -= 2;
    end
    if (out_pos < MAX_NAME) out_pos++;
    c.index = 10'((pos > MAX_NAME - 1) ? MAX_NAME - 1 : pos);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : drive
    name_beat_t nb;
    char_beat_t c;
    logic       give;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      give = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) begin
        nb.mode = uncd_mode_t'(s_tuser);
        nb.data = s_tdata;
        if (decode_beat(nb, c)) expected_chars.push_back(c);
      end
      if (!give) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0) begin
          nb = pend_q.pop_front();
          s_tdata <= nb.data;
          s_tuser <= nb.mode;
          give = 1'b1;
          if (burst_left <= 1) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
          end else begin
            burst_left--;
          end
        end
      end
      s_tvalid <= give;
    end
  end

  always @(posedge clk) begin : watch
    char_beat_t got;
    char_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.code = m_tdata[15:0];
      got.index = m_tdata[25:16];
      got.is_end = m_tlast;
      got.past_end = m_tuser[0];
      if (expected_chars.size() == 0) begin
        if (errors < 10)
          $display("Unexpected beat: code %h index %0d is_end %b past_end %b",
                   got.code, got.index, got.is_end, got.past_end);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (got.code !== want.code || got.index !== want.index ||
            got.is_end !== want.is_end || got.past_end !== want.past_end) begin
          if (errors < 10)
            $display("Mismatch: expected code %h index %0d is_end %b past_end %b, got code %h index %0d is_end %b past_end %b",
                     want.code, want.index, want.is_end, want.past_end,
                     got.code, got.index, got.is_end, got.past_end);
          errors++;
        end
      end
    end
    rdy_tick++;
    if (rdy_left == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_left = $urandom_range(64, 256);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (rdy_tick % 4 == 0);
      default: m_tready <= (rdy_tick % 16 >= 12);
    endcase
  end

  task automatic push_beat(input uncd_mode_t m, input logic [7:0] d);
    name_beat_t nb;
    nb.mode = m;
    nb.data = d;
    pend_q.push_back(nb);
    if (m != MODE_NONE) fed++;
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pend_q.size() != 0 || s_tvalid || expected_chars.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [10:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap = v;
  endtask

  task automatic queue_name(input bit big, input bit cut, input bit partial);
    logic [7:0] enc[$];
    logic [7:0] flag;
    logic [7:0] len;
    int         groups;
    int         nchars;
    int         beats;
    int         r;
    uncd_code_t code;
    groups = $urandom_range(0, 4);
    nchars = 0;
    enc.push_back(8'($urandom));
    for (int g = 0; g < groups; g++) begin
      flag = 8'($urandom);
      enc.push_back(flag);
      for (int k = 3; k >= 0; k--) begin
        code = uncd_code_t'(flag[2*k +: 2]);
        case (code)
          CODE_LIT, CODE_BASE: begin
            enc.push_back(8'($urandom));
            nchars++;
          end
          CODE_PAIR: begin
            enc.push_back(8'($urandom));
            enc.push_back(8'($urandom));
            nchars++;
          end
          default: begin
            len = big ? 8'($urandom) : {1'($urandom), 7'($urandom_range(0, 5))};
            enc.push_back(len);
            if (len[7]) enc.push_back(8'($urandom));
            nchars += len[6:0] + 2;
          end
        endcase
      end
    end
    if (cut) begin
      repeat ($urandom_range(1, 3)) if (enc.size() > 1) enc.delete(enc.size() - 1);
    end
    foreach (enc[i]) push_beat(MODE_LOAD, enc[i]);
    beats = partial ? $urandom_range(0, nchars) : nchars + $urandom_range(1, 3);
    if (beats > 300) beats = 300;
    for (int i = 0; i < beats; i++) begin
      r = $urandom_range(0, 199);
      if (r < 8) push_beat(MODE_NONE, 8'($urandom));
      else if (r < 13) push_beat(MODE_LOAD, 8'($urandom));
      else if (r == 13) push_beat(MODE_RESTART, 8'($urandom));
      push_beat(MODE_CHAR, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int start;
    int phase;
    int pick;
    clear_decoder();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (SAMPLE_NAME[i]) push_beat(MODE_LOAD, SAMPLE_NAME[i]);
    push_beat(MODE_NONE, 8'hC3);
    foreach (SAMPLE_NATIVE[i]) push_beat(MODE_CHAR, SAMPLE_NATIVE[i]);
    push_beat(MODE_RESTART, 8'h00);
    push_beat(MODE_CHAR, 8'h7E);
    settle();

    set_capacity(11'd1024);
    push_beat(MODE_RESTART, 8'hFF);
    push_beat(MODE_LOAD, 8'($urandom));
    for (int i = 1; i < ENC_DEPTH + 4; i++)
      push_beat(MODE_LOAD, ((i - 1) % 9 == 0) ? 8'hAA : 8'($urandom));
    repeat (1040) push_beat(MODE_CHAR, 8'($urandom));
    settle();

    set_capacity(11'd2047);
    push_beat(MODE_RESTART, 8'h00);
    push_beat(MODE_LOAD, 8'($urandom));
    repeat (2) begin
      push_beat(MODE_LOAD, 8'hFF);
      repeat (4) begin
        if ($urandom_range(0, 1) == 1) begin
          push_beat(MODE_LOAD, 8'hFF);
          push_beat(MODE_LOAD, 8'($urandom));
        end else begin
          push_beat(MODE_LOAD, 8'h7F);
        end
      end
    end
    repeat (1030) push_beat(MODE_CHAR, 8'($urandom));
    settle();

    start = fed;
    phase = 0;
    while (fed - start < 600) begin
      if (phase < 6) begin
        set_capacity(CAP_EXTREMES[phase]);
      end else begin
        pick = $urandom_range(0, 7);
        if (pick < 3) set_capacity(11'($urandom_range(3, 48)));
        else if (pick < 5) set_capacity(11'($urandom_range(0, 2047)));
        else if (pick == 5) set_capacity(11'd1024);
      end
      if (phase < 6 || $urandom_range(0, 3) != 0) push_beat(MODE_RESTART, 8'($urandom));
      queue_name($urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0,
                 $urandom_range(0, 5) == 0);
      settle();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
